[src/audio_impairment_and_gain_core_assert.svh]
// Assertion macros shared by the audio impairment and gain checks
`ifndef AUDIO_IMPAIRMENT_AND_GAIN_CORE_ASSERT_SVH
`define AUDIO_IMPAIRMENT_AND_GAIN_CORE_ASSERT_SVH

// check cons in the same cycle as ante
`define AIG_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("audio impairment core: check failed");

// check cons in the cycle after ante
`define AIG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("audio impairment core: check failed");

`endif

[src/aig_pkg.sv]
// Types and constants for the audio impairment and gain core
package aig_pkg;

	localparam int SAMPLE_W      = 32;
	localparam int CHANNEL_W     = 3;
	localparam int INDEX_W       = 13;
	localparam int FRAME_W       = 14;
	localparam int MASK_W        = 10;
	localparam int GAIN_W        = 24;
	localparam int CFG_IDX_W     = 2;
	localparam int LFSR_W        = 31;
	localparam int GAIN_FRAC_W   = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_EFFECT_MASK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_ENABLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_FACTOR = 2'd2;

	localparam logic [GAIN_W-1:0] GAIN_UNITY = 24'd65536;

	// effect bits as seen by the right channel; left uses the next bit up
	localparam int FX_MUTE    = 0;
	localparam int FX_NOISE   = 2;
	localparam int FX_BUZZ    = 4;
	localparam int FX_ATTEN   = 6;
	localparam int FX_AMPLIFY = 8;
	localparam int FX_W       = MASK_W - 1;

	localparam logic [CHANNEL_W-1:0] CHANNEL_LEFT = 3'd0;

	localparam logic signed [SAMPLE_W-1:0] BUZZ_VALUE = -32'sd200000000;
	localparam int BUZZ_RUN = 4;

	localparam logic [LFSR_W-1:0] LFSR_TAPS = 31'h4800_0000;
	localparam logic [LFSR_W-1:0] LFSR_SEED = 31'd1;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7fff_ffff;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [MASK_W-1:0] effect_mask;
		logic              gain_enable;
		logic [GAIN_W-1:0] gain_factor;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic live;
	} stage_ctl_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0]  sample;
		logic        [CHANNEL_W-1:0] channel;
		logic                        buzz_hit;
	} front_t;

endpackage

[src/aig_cfg_regs.sv]
// Configuration registers of the audio impairment and gain core
module aig_cfg_regs
	import aig_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GAIN_W-1:0]    cfg_data,
	output cfg_t                 cfg
);

	logic [MASK_W-1:0] effect_mask_q;
	logic              gain_enable_q;
	logic [GAIN_W-1:0] gain_factor_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			effect_mask_q <= '0;
			gain_enable_q <= 1'b0;
			gain_factor_q <= GAIN_UNITY;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_EFFECT_MASK: effect_mask_q <= cfg_data[MASK_W-1:0];
				CFG_GAIN_ENABLE: gain_enable_q <= cfg_data[0];
				CFG_GAIN_FACTOR: gain_factor_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.effect_mask = effect_mask_q;
	assign cfg.gain_enable = gain_enable_q;
	assign cfg.gain_factor = gain_factor_q;

endmodule

[src/aig_front.sv]
// Input register stage with buzz region detection
module aig_front
	import aig_pkg::*;
#(
	parameter int MAX_FRAME_SAMPLES = 8192,
	parameter int BUZZ_PERIOD       = 16
) (
	input  logic                       clk,
	input  logic                       load,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	input  logic [CHANNEL_W-1:0]       channel,
	input  logic [INDEX_W-1:0]         sample_index,
	input  logic [FRAME_W-1:0]         frame_samples,
	output front_t                     stage_s1
);

	localparam int PER_W     = $clog2(BUZZ_PERIOD);
	localparam int SHIFT_I   = INDEX_W + PER_W;
	localparam int SHIFT_F   = FRAME_W + PER_W;
	localparam int PROD_I_W  = INDEX_W + SHIFT_I + 1;
	localparam int PROD_F_W  = FRAME_W + SHIFT_F + 1;
	localparam longint RECIP_I = ((longint'(1) << SHIFT_I) + BUZZ_PERIOD - 1) / BUZZ_PERIOD;
	localparam longint RECIP_F = ((longint'(1) << SHIFT_F) + BUZZ_PERIOD - 1) / BUZZ_PERIOD;
	localparam bit RUN_COVERS_PERIOD = (BUZZ_PERIOD <= BUZZ_RUN);

	logic [FRAME_W-1:0]  frame_c;
	logic [INDEX_W-1:0]  index_back;
	logic [PROD_I_W-1:0] prod_idx;
	logic [PROD_I_W-1:0] prod_back;
	logic [PROD_F_W-1:0] prod_frame;
	logic [INDEX_W-1:0]  blk_idx;
	logic [INDEX_W-1:0]  blk_back;
	logic [FRAME_W-1:0]  blk_frame;
	logic                in_run;
	logic                in_whole;

	always_comb begin
		frame_c = (32'(frame_samples) > MAX_FRAME_SAMPLES) ?
			FRAME_W'(MAX_FRAME_SAMPLES) : frame_samples;
		index_back = sample_index - INDEX_W'(BUZZ_RUN);
		prod_idx   = PROD_I_W'(sample_index) * PROD_I_W'(RECIP_I);
		prod_back  = PROD_I_W'(index_back) * PROD_I_W'(RECIP_I);
		prod_frame = PROD_F_W'(frame_c) * PROD_F_W'(RECIP_F);
		blk_idx    = INDEX_W'(prod_idx >> SHIFT_I);
		blk_back   = INDEX_W'(prod_back >> SHIFT_I);
		blk_frame  = FRAME_W'(prod_frame >> SHIFT_F);
		// within the run when stepping back by the run length leaves the block
		in_run = RUN_COVERS_PERIOD || (32'(sample_index) < BUZZ_RUN) ||
			(blk_back != blk_idx);
		in_whole = FRAME_W'(blk_idx) < blk_frame;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			stage_s1.sample   <= sample_in;
			stage_s1.channel  <= channel;
			stage_s1.buzz_hit <= in_run && in_whole;
		end
	end

endmodule

[src/aig_effects.sv]
// Per-channel impairment stage with the noise generator
module aig_effects
	import aig_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  stage_ctl_t                 ctl,
	input  logic [MASK_W-1:0]          effect_mask,
	input  front_t                     stage_s1,
	output logic signed [SAMPLE_W-1:0] sample_s2
);

	logic [LFSR_W-1:0]          lfsr_q;
	logic [LFSR_W-1:0]          lfsr_next;
	logic [FX_W-1:0]            fx;
	logic                       lr;
	logic signed [SAMPLE_W-1:0] v_mute;
	logic signed [SAMPLE_W-1:0] v_noise;
	logic signed [SAMPLE_W-1:0] v_buzz;
	logic signed [SAMPLE_W-1:0] v_atten;
	logic signed [SAMPLE_W-1:0] v_amp;

	always_comb begin
		lr = (stage_s1.channel[CHANNEL_W-1:1] == '0);
		fx = (stage_s1.channel == CHANNEL_LEFT) ? effect_mask[MASK_W-1:1] :
			effect_mask[FX_W-1:0];
		if (!lr) begin
			fx = '0;
		end
		lfsr_next = {1'b0, lfsr_q[LFSR_W-1:1]} ^ (lfsr_q[0] ? LFSR_TAPS : '0);

		v_mute  = fx[FX_MUTE] ? '0 : stage_s1.sample;
		v_noise = fx[FX_NOISE] ? signed'({1'b0, lfsr_next}) : v_mute;
		v_buzz  = (fx[FX_BUZZ] && stage_s1.buzz_hit) ? BUZZ_VALUE : v_noise;
		// divide by four toward zero
		v_atten = fx[FX_ATTEN] ?
			((v_buzz + (v_buzz[SAMPLE_W-1] ? 32'sd3 : 32'sd0)) >>> 2) : v_buzz;
		if (!fx[FX_AMPLIFY]) begin
			v_amp = v_atten;
		end else if ((v_atten[SAMPLE_W-1:SAMPLE_W-4] == 4'b0000) ||
			(v_atten[SAMPLE_W-1:SAMPLE_W-4] == 4'b1111)) begin
			v_amp = v_atten <<< 3;
		end else begin
			v_amp = v_atten[SAMPLE_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= LFSR_SEED;
		end else if (ctl.load && ctl.live && fx[FX_NOISE]) begin
			lfsr_q <= lfsr_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			sample_s2 <= v_amp;
		end
	end

endmodule

[src/aig_gain.sv]
// Gain stage and result register
module aig_gain
	import aig_pkg::*;
(
	input  logic                       clk,
	input  logic                       load,
	input  logic                       gain_enable,
	input  logic [GAIN_W-1:0]          gain_factor,
	input  logic signed [SAMPLE_W-1:0] sample_s2,
	output logic signed [SAMPLE_W-1:0] sample_s3
);

	localparam int PROD_W  = SAMPLE_W + GAIN_W + 1;
	localparam int QUOT_W  = PROD_W - GAIN_FRAC_W;

	logic signed [GAIN_W:0]   gain_s;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_b;
	logic signed [QUOT_W-1:0] quot;
	logic signed [SAMPLE_W-1:0] gained;

	always_comb begin
		gain_s = signed'({1'b0, gain_factor});
		prod   = PROD_W'(sample_s2) * PROD_W'(gain_s);
		// bias negatives so the shift truncates toward zero
		prod_b = prod + (prod[PROD_W-1] ?
			PROD_W'((1 << GAIN_FRAC_W) - 1) : PROD_W'(0));
		quot   = QUOT_W'(prod_b >>> GAIN_FRAC_W);
		if ((&quot[QUOT_W-1:SAMPLE_W-1]) || !(|quot[QUOT_W-1:SAMPLE_W-1])) begin
			gained = quot[SAMPLE_W-1:0];
		end else begin
			gained = quot[QUOT_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sample_s3 <= gain_enable ? gained : sample_s2;
		end
	end

endmodule

[src/audio_impairment_and_gain_core.sv]
// Audio impairment and gain core: three-stage pipeline, one sample per clock.
// A sample is accepted at every clock while the output is taken. Its result is
// registered in the input, impairment and gain stages in that order and is
// presented from the gain stage. The three stages are the input register with
// buzz region detection, the per-channel impairment stage with the noise LFSR,
// and the gain multiply with saturation, which also holds the result. Empty
// stages close up under output stall, so the input stalls only when all three
// stages hold samples and the output is stalled. Configuration writes are taken
// at any clock (cfg_ready is always high) and should be made while no samples
// are in flight.
module audio_impairment_and_gain_core
	import aig_pkg::*;
#(
	parameter int MAX_FRAME_SAMPLES = 8192,
	parameter int BUZZ_PERIOD       = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [GAIN_W-1:0]          cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	input  logic [CHANNEL_W-1:0]       channel,
	input  logic [INDEX_W-1:0]         sample_index,
	input  logic [FRAME_W-1:0]         frame_samples,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] sample_out
);

	cfg_t                       cfg;
	front_t                     stage_s1;
	logic signed [SAMPLE_W-1:0] sample_s2;
	logic signed [SAMPLE_W-1:0] sample_s3;
	logic                       valid_s1;
	logic                       valid_s2;
	logic                       valid_s3;
	logic                       adv1;
	logic                       adv2;
	logic                       adv3;
	stage_ctl_t                 fx_ctl;

	always_comb begin
		adv3 = !valid_s3 || !out_stall;
		adv2 = !valid_s2 || adv3;
		adv1 = !valid_s1 || adv2;
		fx_ctl.load = adv2;
		fx_ctl.live = valid_s1;
	end

	assign in_stall   = !adv1;
	assign out_valid  = valid_s3;
	assign sample_out = sample_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= in_valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	aig_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	aig_front #(
		.MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES),
		.BUZZ_PERIOD       (BUZZ_PERIOD)
	) u_front (
		.clk           (clk),
		.load          (adv1),
		.sample_in     (sample_in),
		.channel       (channel),
		.sample_index  (sample_index),
		.frame_samples (frame_samples),
		.stage_s1      (stage_s1)
	);

	aig_effects u_effects (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (fx_ctl),
		.effect_mask (cfg.effect_mask),
		.stage_s1    (stage_s1),
		.sample_s2   (sample_s2)
	);

	aig_gain u_gain (
		.clk         (clk),
		.load        (adv3),
		.gain_enable (cfg.gain_enable),
		.gain_factor (cfg.gain_factor),
		.sample_s2   (sample_s2),
		.sample_s3   (sample_s3)
	);

endmodule

[src/aig_checker.sv]
// Port-level checks for the audio impairment and gain core
`include "audio_impairment_and_gain_core_assert.svh"

module aig_checker
	import aig_pkg::*;
(
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic signed [SAMPLE_W-1:0] sample_out
);

	`AIG_ASSERT_NOW(a_stall_only_when_full, in_stall, out_valid && out_stall)
	`AIG_ASSERT_NEXT(a_drains, (!out_stall && !in_valid) [*3], !out_valid)
	`AIG_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid)
	`AIG_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(sample_out))

endmodule

bind audio_impairment_and_gain_core aig_checker u_aig_checker (.*);
